/* rtl/mlpis_pkg.sv */
// Shared types, constants and the activation table of the perceptron core.
`timescale 1ns / 1ps
package mlpis_pkg;

   localparam int SAMPLE_COUNT = 7;
   localparam int ACT_ENTRIES  = 1024;
   localparam logic signed [17:0] Q_ONE = 18'sd65536;
   localparam logic signed [31:0] ACT_LIMIT = 32'sd524288;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_START,
      OP_CLIP,
      OP_SUB,
      OP_MULX,
      OP_STOREX,
      OP_LOADZ,
      OP_LOADACC,
      OP_MULW,
      OP_ACCUM,
      OP_ACTH,
      OP_MULO,
      OP_ACCZ,
      OP_ACTZ,
      OP_RESULT
   } dp_op_type;

   typedef struct packed {
      logic      mem_we;
      logic      rd_zero;
      dp_op_type op;
   } dp_cmd_type;

   typedef logic signed [17:0] act_rom_type [ACT_ENTRIES];

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
         sat_add = s[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else begin
         sat_add = s[31:0];
      end
   endfunction

   function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} - {b[31], b};
      if (s[32] != s[31]) begin
         sat_sub = s[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else begin
         sat_sub = s[31:0];
      end
   endfunction

   // floor the Q32.32 product back to Q16.16 and clamp
   function automatic logic signed [31:0] q_sat(input logic signed [63:0] p);
      logic signed [63:0] sh;
      sh = p >>> 16;
      if (sh > 64'sh000000007FFFFFFF) begin
         q_sat = 32'sh7FFFFFFF;
      end else if (sh < -64'sh0000000080000000) begin
         q_sat = 32'sh80000000;
      end else begin
         q_sat = sh[31:0];
      end
   endfunction

   // f(x) = (1-p)/(1+p) with p = exp(-x) in Q2.62, rounded to Q2.16
   function automatic logic signed [17:0] act_of(input logic [63:0] p);
      logic [63:0] num;
      logic [63:0] den;
      logic [17:0] q;
      num = 64'h4000000000000000 - p;
      den = 64'h4000000000000000 + p;
      q   = '0;
      for (int i = 0; i < 17; i++) begin
         num = num << 1;
         q   = q << 1;
         if (num >= den) begin
            num  = num - den;
            q[0] = 1'b1;
         end
      end
      act_of = 18'((q + 18'd1) >> 1);
   endfunction

   function automatic act_rom_type build_act_rom();
      act_rom_type rom;
      logic [63:0]  step;
      logic [63:0]  term;
      logic [63:0]  p;
      logic [127:0] full;
      logic signed [17:0] g;
      step = 64'h4000000000000000;
      term = 64'h4000000000000000;
      p    = 64'h4000000000000000;
      // exp(-1/64) from its series
      for (int k = 1; k < 14; k++) begin
         term = term / 64'(64 * k);
         if (k % 2 == 1) begin
            step = step - term;
         end else begin
            step = step + term;
         end
      end
      for (int n = 0; n <= 512; n++) begin
         g = act_of(p);
         if (n < 512) begin
            rom[512 + n] = g;
         end
         if (n >= 1) begin
            rom[512 - n] = -g;
         end
         full = 128'(p) * 128'(step);
         p    = full[125:62];
      end
      build_act_rom = rom;
   endfunction

   localparam act_rom_type ACT_ROM = build_act_rom();

endpackage

/* rtl/mlpis_datapath.sv */
// Datapath: coefficient memory, shared multiplier, accumulators and activation table.
`timescale 1ns / 1ps
module mlpis_datapath
   import mlpis_pkg::*;
#(
   parameter int INPUT_COUNT = 7,
   parameter int COEF_DEPTH  = 128,
   parameter int ADDR_W      = 7,
   parameter int KW          = 3
) (
   input  logic                     clock,
   input  dp_cmd_type               cmd,
   input  logic [ADDR_W-1:0]        rd_addr,
   input  logic [KW-1:0]            x_idx,
   input  logic [6:0]               req_coef_addr,
   input  logic signed [31:0]       req_coef_value,
   input  logic signed [31:0]       req_in_ph,
   input  logic signed [31:0]       req_in_ph_slope,
   input  logic signed [31:0]       req_in_do,
   input  logic signed [31:0]       req_in_do_slope,
   input  logic signed [31:0]       req_in_orp,
   input  logic signed [31:0]       req_in_orp_diff,
   input  logic signed [31:0]       req_in_orp_slope,
   output logic signed [17:0]       rsp_score
);

   localparam int MW = $clog2(COEF_DEPTH);

   logic signed [31:0] mem [COEF_DEPTH];
   logic signed [31:0] mem_rdata_ff;
   logic               rd_zero_ff;
   logic signed [31:0] raw_ff [INPUT_COUNT];
   logic signed [31:0] x_ff [INPUT_COUNT];
   logic signed [31:0] xt_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] acc_ff;
   logic signed [31:0] z2_ff;
   logic signed [17:0] rom_ff;
   logic               lo_ff;
   logic               hi_ff;
   logic signed [17:0] score_ff;

   logic signed [31:0] sample [SAMPLE_COUNT];
   logic signed [31:0] rdata;
   logic signed [31:0] raw_sel;
   logic signed [17:0] act_val;
   logic signed [31:0] mul_a;
   logic signed [63:0] prod_in;
   logic signed [31:0] act_src;

   assign sample[0] = req_in_ph;
   assign sample[1] = req_in_ph_slope;
   assign sample[2] = req_in_do;
   assign sample[3] = req_in_do_slope;
   assign sample[4] = req_in_orp;
   assign sample[5] = req_in_orp_diff;
   assign sample[6] = req_in_orp_slope;

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[MW'(req_coef_addr)] <= req_coef_value;
      end
      mem_rdata_ff <= mem[MW'(32'(rd_addr))];
      rd_zero_ff   <= cmd.rd_zero;
   end

   assign rdata   = rd_zero_ff ? 32'sd0 : mem_rdata_ff;
   assign raw_sel = raw_ff[x_idx];
   assign act_val = lo_ff ? -Q_ONE : (hi_ff ? Q_ONE : rom_ff);

   always_comb begin
      case (cmd.op)
         OP_MULX: mul_a = xt_ff;
         OP_MULW: mul_a = x_ff[x_idx];
         default: mul_a = 32'(act_val);
      endcase
   end

   assign prod_in = mul_a * rdata;
   assign act_src = (cmd.op == OP_ACTZ) ? z2_ff : acc_ff;

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_START: begin
            for (int k = 0; k < INPUT_COUNT; k++) begin
               raw_ff[k] <= (k < SAMPLE_COUNT) ? sample[k] : 32'sd0;
            end
         end
         OP_CLIP:    xt_ff <= (raw_sel > rdata) ? rdata : raw_sel;
         OP_SUB:     xt_ff <= sat_sub(xt_ff, rdata);
         OP_MULX, OP_MULW, OP_MULO: prod_ff <= prod_in;
         OP_STOREX:  x_ff[x_idx] <= q_sat(prod_ff);
         OP_LOADZ:   z2_ff <= rdata;
         OP_LOADACC: acc_ff <= rdata;
         OP_ACCUM:   acc_ff <= sat_add(acc_ff, q_sat(prod_ff));
         OP_ACCZ:    z2_ff <= sat_add(z2_ff, q_sat(prod_ff));
         OP_ACTH, OP_ACTZ: begin
            rom_ff <= ACT_ROM[{~act_src[19], act_src[18:10]}];
            lo_ff  <= act_src < -ACT_LIMIT;
            hi_ff  <= act_src >= ACT_LIMIT;
         end
         OP_RESULT:  score_ff <= act_val;
         default: ;
      endcase
   end

   assign rsp_score = score_ff;

endmodule

/* rtl/mlpis_controller.sv */
// Controller: sequences scaling, hidden layer, output layer and the result handshake.
`timescale 1ns / 1ps
module mlpis_controller
   import mlpis_pkg::*;
#(
   parameter int INPUT_COUNT  = 7,
   parameter int HIDDEN_COUNT = 8,
   parameter int COEF_DEPTH   = 128,
   parameter int ADDR_W       = 7,
   parameter int KW           = 3,
   parameter int JW           = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_cmd,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dp_cmd_type        cmd,
   output logic [ADDR_W-1:0] rd_addr,
   output logic [KW-1:0]     x_idx
);

   localparam int STRIDE = INPUT_COUNT + 1;
   localparam int OBASE  = HIDDEN_COUNT * STRIDE;
   localparam int SBASE  = OBASE + HIDDEN_COUNT + 1;

   typedef enum logic [4:0] {
      S_IDLE, S_X0, S_X1, S_X2, S_X3, S_X4, S_O0, S_O1,
      S_H0, S_H1, S_H2, S_H3, S_A0, S_A1, S_A2, S_F0, S_F1
   } state_type;

   state_type       state_ff, state_in;
   logic [KW-1:0]   k_ff, k_in;
   logic [JW-1:0]   j_ff, j_in;
   logic            rsp_valid_ff, rsp_valid_in;
   int              addr;
   logic            k_last;
   logic            j_last;

   assign k_last = (32'(k_ff) == INPUT_COUNT - 1);
   assign j_last = (32'(j_ff) == HIDDEN_COUNT - 1);

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.mem_we   = 1'b0;
      cmd.op       = OP_NONE;
      addr         = 0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_cmd) begin
                  cmd.op   = OP_START;
                  k_in     = '0;
                  state_in = S_X0;
               end else begin
                  cmd.mem_we = 1'b1;
               end
            end
         end
         S_X0: begin
            addr     = SBASE + 3 * int'(k_ff);
            state_in = S_X1;
         end
         S_X1: begin
            addr     = SBASE + 3 * int'(k_ff) + 1;
            cmd.op   = OP_CLIP;
            state_in = S_X2;
         end
         S_X2: begin
            addr     = SBASE + 3 * int'(k_ff) + 2;
            cmd.op   = OP_SUB;
            state_in = S_X3;
         end
         S_X3: begin
            cmd.op   = OP_MULX;
            state_in = S_X4;
         end
         S_X4: begin
            cmd.op = OP_STOREX;
            if (k_last) begin
               state_in = S_O0;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_X0;
            end
         end
         S_O0: begin
            addr     = OBASE;
            state_in = S_O1;
         end
         S_O1: begin
            cmd.op   = OP_LOADZ;
            j_in     = '0;
            state_in = S_H0;
         end
         S_H0: begin
            addr     = int'(j_ff) * STRIDE;
            state_in = S_H1;
         end
         S_H1: begin
            addr     = int'(j_ff) * STRIDE + 1;
            cmd.op   = OP_LOADACC;
            k_in     = '0;
            state_in = S_H2;
         end
         S_H2: begin
            cmd.op   = OP_MULW;
            state_in = S_H3;
         end
         S_H3: begin
            // fetch the next weight while the sum updates
            cmd.op = OP_ACCUM;
            if (k_last) begin
               state_in = S_A0;
            end else begin
               addr     = int'(j_ff) * STRIDE + 2 + int'(k_ff);
               k_in     = k_ff + 1'b1;
               state_in = S_H2;
            end
         end
         S_A0: begin
            addr     = OBASE + 1 + int'(j_ff);
            cmd.op   = OP_ACTH;
            state_in = S_A1;
         end
         S_A1: begin
            cmd.op   = OP_MULO;
            state_in = S_A2;
         end
         S_A2: begin
            cmd.op = OP_ACCZ;
            if (j_last) begin
               state_in = S_F0;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_H0;
            end
         end
         S_F0: begin
            cmd.op   = OP_ACTZ;
            state_in = S_F1;
         end
         S_F1: begin
            // hold until the previous result is taken
            if (!(rsp_valid_ff && !rsp_ready)) begin
               cmd.op       = OP_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      cmd.rd_zero = (addr >= COEF_DEPTH);
   end

   assign rd_addr   = ADDR_W'(addr);
   assign x_idx     = k_ff;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      32'(k_ff) < INPUT_COUNT) else $error("input index out of range");
   a_j_range: assert property (@(posedge clock) disable iff (reset)
      32'(j_ff) < HIDDEN_COUNT) else $error("hidden index out of range");
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_we |-> (req_ready && req_valid && !req_cmd))
      else $error("coefficient write outside idle");
   a_result: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RESULT) |=> rsp_valid) else $error("result not presented");
`endif

endmodule

/* rtl/mlp_inference_with_input_scaling_core.sv */
// Top level of the two-layer perceptron core with input scaling.
`timescale 1ns / 1ps
// A request with cmd 0 writes one coefficient word and gives no response. A request
// with cmd 1 clips, offsets and scales the seven samples, runs the hidden and output
// layers through one shared 32x32 multiplier and one coefficient read port, and
// returns one score. Each input is clipped, offset, scaled and stored in turn, and
// each hidden product is a multiply and an accumulate, with the next weight fetched
// alongside. The next request is accepted while a score waits.
module mlp_inference_with_input_scaling_core
   import mlpis_pkg::*;
#(
   parameter int INPUT_COUNT  = 7,
   parameter int HIDDEN_COUNT = 8,
   parameter int COEF_DEPTH   = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic [6:0]         req_coef_addr,
   input  logic signed [31:0] req_coef_value,
   input  logic signed [31:0] req_in_ph,
   input  logic signed [31:0] req_in_ph_slope,
   input  logic signed [31:0] req_in_do,
   input  logic signed [31:0] req_in_do_slope,
   input  logic signed [31:0] req_in_orp,
   input  logic signed [31:0] req_in_orp_diff,
   input  logic signed [31:0] req_in_orp_slope,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [17:0] rsp_score
);

   localparam int LAST_ADDR = (HIDDEN_COUNT + 1) * (INPUT_COUNT + 1) + 3 * INPUT_COUNT;
   localparam int ADDR_W    = $clog2(LAST_ADDR + 1);
   localparam int KW        = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
   localparam int JW        = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;

   dp_cmd_type        cmd;
   logic [ADDR_W-1:0] rd_addr;
   logic [KW-1:0]     x_idx;

   mlpis_controller #(
      .INPUT_COUNT(INPUT_COUNT), .HIDDEN_COUNT(HIDDEN_COUNT), .COEF_DEPTH(COEF_DEPTH),
      .ADDR_W(ADDR_W), .KW(KW), .JW(JW)
   ) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_cmd(req_cmd), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .cmd(cmd), .rd_addr(rd_addr), .x_idx(x_idx)
   );

   mlpis_datapath #(
      .INPUT_COUNT(INPUT_COUNT), .COEF_DEPTH(COEF_DEPTH), .ADDR_W(ADDR_W), .KW(KW)
   ) u_dp (
      .clock(clock),
      .cmd(cmd), .rd_addr(rd_addr), .x_idx(x_idx),
      .req_coef_addr(req_coef_addr), .req_coef_value(req_coef_value),
      .req_in_ph(req_in_ph), .req_in_ph_slope(req_in_ph_slope),
      .req_in_do(req_in_do), .req_in_do_slope(req_in_do_slope),
      .req_in_orp(req_in_orp), .req_in_orp_diff(req_in_orp_diff),
      .req_in_orp_slope(req_in_orp_slope),
      .rsp_score(rsp_score)
   );

endmodule

/* bench/mlp_inference_with_input_scaling_core_checker.sv */
// Score predictor and response checker for the perceptron core.
`timescale 1ns / 1ps
module mlp_inference_with_input_scaling_core_checker
   import mlpis_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_cmd,
   input  logic [6:0]         req_coef_addr,
   input  logic signed [31:0] req_coef_value,
   input  logic signed [31:0] req_in_ph,
   input  logic signed [31:0] req_in_ph_slope,
   input  logic signed [31:0] req_in_do,
   input  logic signed [31:0] req_in_do_slope,
   input  logic signed [31:0] req_in_orp,
   input  logic signed [31:0] req_in_orp_diff,
   input  logic signed [31:0] req_in_orp_slope,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [17:0] rsp_score,
   output int                 fail_count,
   output int                 outstanding
);

   localparam int NEURON_COUNT = 8;
   localparam int NEURON_W  = SAMPLE_COUNT + 1;
   localparam int OUT_BASE  = NEURON_COUNT * NEURON_W;
   localparam int SCALE_BASE = OUT_BASE + NEURON_COUNT + 1;
   localparam logic [63:0] UNIT_Q62 = 64'h4000000000000000;

   logic signed [31:0] coef_mem [128];
   logic signed [17:0] sigm_table [1024];
   logic signed [17:0] score_queue [$];

   // (1-p)/(1+p) by long division, rounded to Q2.16
   function automatic logic signed [17:0] bipolar_of(input logic [63:0] p);
      logic [63:0] num;
      logic [63:0] den;
      logic [17:0] quo;
      num = UNIT_Q62 - p;
      den = UNIT_Q62 + p;
      quo = '0;
      for (int i = 0; i < 17; i++) begin
         num = num << 1;
         quo = quo << 1;
         if (num >= den) begin
            num = num - den;
            quo[0] = 1'b1;
         end
      end
      return 18'((quo + 18'd1) >> 1);
   endfunction

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return clamp32(p >>> 16);
   endfunction

   function automatic logic signed [31:0] squash(input logic signed [31:0] x);
      longint idx;
      if (x < -32'sd524288) return -32'sd65536;
      if (x >= 32'sd524288) return 32'sd65536;
      idx = (longint'(x) + 524288) >>> 10;
      return 32'(sigm_table[idx[9:0]]);
   endfunction

   function automatic logic signed [17:0] predict_score(input logic signed [31:0] smp [7]);
      logic signed [31:0] xs [7];
      logic signed [31:0] raw;
      logic signed [31:0] z1;
      logic signed [31:0] z2;
      for (int k = 0; k < SAMPLE_COUNT; k++) begin
         raw = smp[k];
         if (raw > coef_mem[SCALE_BASE + 3*k]) raw = coef_mem[SCALE_BASE + 3*k];
         raw = clamp32(longint'(raw) - longint'(coef_mem[SCALE_BASE + 3*k + 1]));
         xs[k] = fx_mul(raw, coef_mem[SCALE_BASE + 3*k + 2]);
      end
      z2 = coef_mem[OUT_BASE];
      for (int j = 0; j < NEURON_COUNT; j++) begin
         z1 = coef_mem[j*NEURON_W];
         for (int k = 0; k < SAMPLE_COUNT; k++)
            z1 = clamp32(longint'(z1) + longint'(fx_mul(coef_mem[j*NEURON_W + 1 + k], xs[k])));
         z2 = clamp32(longint'(z2) + longint'(fx_mul(coef_mem[OUT_BASE + 1 + j], squash(z1))));
      end
      return 18'(squash(z2));
   endfunction

   initial begin
      logic [63:0] step;
      logic [63:0] term;
      logic [63:0] p;
      logic [127:0] full;
      logic signed [17:0] g;
      step = UNIT_Q62;
      term = UNIT_Q62;
      p = UNIT_Q62;
      // exp(-1/64) from its series
      for (int k = 1; k < 14; k++) begin
         term = term / 64'(64 * k);
         if (k % 2 == 1) step = step - term;
         else step = step + term;
      end
      for (int n = 0; n <= 512; n++) begin
         g = bipolar_of(p);
         if (n < 512) sigm_table[512 + n] = g;
         if (n >= 1) sigm_table[512 - n] = -g;
         full = {64'd0, p} * {64'd0, step};
         p = full[125:62];
      end
   end

   always @(posedge clock) begin
      logic signed [31:0] smp [7];
      logic signed [17:0] want;
      if (!reset) begin
         // retire the response before taking the request of the same edge
         if (rsp_valid && rsp_ready) begin
            if (score_queue.size() == 0) begin
               $display("%0t: unexpected response, score %0d", $time, rsp_score);
               fail_count++;
            end else begin
               want = score_queue.pop_front();
               if (rsp_score !== want) begin
                  $display("%0t: score mismatch, expected %0d, actual %0d",
                           $time, want, rsp_score);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (!req_cmd) begin
               coef_mem[req_coef_addr] = req_coef_value;
            end else begin
               smp = '{req_in_ph, req_in_ph_slope, req_in_do, req_in_do_slope,
                       req_in_orp, req_in_orp_diff, req_in_orp_slope};
               score_queue = {score_queue, predict_score(smp)};
            end
         end
         outstanding = score_queue.size();
      end else begin
         fail_count  = 0;
         outstanding = 0;
      end
   end

endmodule

/* bench/mlp_inference_with_input_scaling_core_tb.sv */
// Stimulus and verdict for the perceptron core.
`timescale 1ns / 1ps
module mlp_inference_with_input_scaling_core_tb;

   localparam bit CMD_WRITE = 1'b0;
   localparam bit CMD_INFER = 1'b1;
   localparam int SCALE_BASE = 73;
   localparam int USED_WORDS = 94;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_cmd;
   logic [6:0]         req_coef_addr;
   logic signed [31:0] req_coef_value;
   logic signed [31:0] req_in_ph;
   logic signed [31:0] req_in_ph_slope;
   logic signed [31:0] req_in_do;
   logic signed [31:0] req_in_do_slope;
   logic signed [31:0] req_in_orp;
   logic signed [31:0] req_in_orp_diff;
   logic signed [31:0] req_in_orp_slope;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [17:0] rsp_score;
   int                 fail_count;
   int                 outstanding;

   logic signed [31:0] smp [7];
   bit                 steady;
   bit                 squeeze_go;

   mlp_inference_with_input_scaling_core uut (.*);

   mlp_inference_with_input_scaling_core_checker checker_i (.*);

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [31:0] span(input int lim);
      return $signed($urandom_range(0, 2*lim)) - lim;
   endfunction

   // a value suited to what the address holds
   function automatic logic signed [31:0] sane_coef(input int addr);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return $urandom();
      if (r < 4) return 32'sh7FFFFFFF;
      if (r < 5) return 32'sh80000000;
      if (addr < 64) return span(98304);
      if (addr < SCALE_BASE) return span(131072);
      if (addr >= USED_WORDS) return $urandom();
      case ((addr - SCALE_BASE) % 3)
         0: return span(786432);
         1: return span(131072);
         default: return span(65536);
      endcase
   endfunction

   task automatic issue(input bit cmd, input logic [6:0] addr, input logic signed [31:0] val);
      int g;
      g = steady ? 0 : gap_len();
      if (g > 0) begin
         req_valid = 1'b0;
         repeat (g) @(negedge clock);
      end
      req_cmd = cmd;
      req_coef_addr = addr;
      req_coef_value = val;
      {req_in_ph, req_in_ph_slope, req_in_do, req_in_do_slope} = {smp[0], smp[1], smp[2], smp[3]};
      {req_in_orp, req_in_orp_diff, req_in_orp_slope} = {smp[4], smp[5], smp[6]};
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic infer_random();
      int r;
      for (int k = 0; k < 7; k++) begin
         r = $urandom_range(0, 99);
         if (r < 80) smp[k] = span(1048576);
         else if (r < 94) smp[k] = $urandom();
         else if (r < 97) smp[k] = 32'sh7FFFFFFF;
         else smp[k] = 32'sh80000000;
      end
      issue(CMD_INFER, 7'($urandom()), $urandom());
   endtask

   task automatic infer_all(input logic signed [31:0] v);
      smp = '{v, v, v, v, v, v, v};
      issue(CMD_INFER, 7'($urandom()), $urandom());
   endtask

   // receiver: random stalls, and one long hold-off once the random mix begins
   initial begin
      int stall_left;
      bit squeezed;
      stall_left = 0;
      squeezed = 1'b0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (squeeze_go && !squeezed) begin
            squeezed = 1'b1;
            rsp_ready = 1'b0;
            repeat (3000) @(negedge clock);
         end
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) stall_left = gap_len();
         end
         @(negedge clock);
      end
   end

   initial begin
      logic [6:0] a;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_WRITE;
      req_coef_addr = '0;
      req_coef_value = '0;
      smp = '{default: '0};
      {req_in_ph, req_in_ph_slope, req_in_do, req_in_do_slope} = '0;
      {req_in_orp, req_in_orp_diff, req_in_orp_slope} = '0;
      steady = 1'b0;
      squeeze_go = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // load every word, unused ones too
      for (int i = 0; i < 128; i++) begin
         if (i < 64) issue(CMD_WRITE, 7'(i), span(98304));
         else if (i < SCALE_BASE) issue(CMD_WRITE, 7'(i), span(131072));
         else issue(CMD_WRITE, 7'(i), sane_coef(i));
      end

      // sample extremes
      infer_all(32'sd0);
      infer_all(32'sh7FFFFFFF);
      infer_all(32'sh80000000);
      // saturate offset subtraction and scaling
      issue(CMD_WRITE, 7'(SCALE_BASE + 1), 32'sh80000000);
      issue(CMD_WRITE, 7'(SCALE_BASE + 2), 32'sh7FFFFFFF);
      issue(CMD_WRITE, 7'(SCALE_BASE), 32'sh7FFFFFFF);
      infer_all(32'sh7FFFFFFF);
      issue(CMD_WRITE, 7'(SCALE_BASE + 1), 32'sd65536);
      issue(CMD_WRITE, 7'(SCALE_BASE + 2), 32'sd32768);
      issue(CMD_WRITE, 7'(SCALE_BASE), 32'sd262144);

      // output layer edges of the table: zero output weights, sweep the bias
      for (int j = 65; j < SCALE_BASE; j++) issue(CMD_WRITE, 7'(j), 32'sd0);
      issue(CMD_WRITE, 7'd64, -32'sd524288);
      infer_all(32'sd0);
      issue(CMD_WRITE, 7'd64, -32'sd524289);
      infer_all(32'sd0);
      issue(CMD_WRITE, 7'd64, 32'sd524287);
      infer_all(32'sd0);
      issue(CMD_WRITE, 7'd64, 32'sd524288);
      infer_all(32'sd0);
      for (int j = 64; j < SCALE_BASE; j++) issue(CMD_WRITE, 7'(j), span(131072));

      // random mix, with a long receiver hold-off early on
      squeeze_go = 1'b1;
      for (int n = 0; n < 1740; n++) begin
         if (n % 150 == 0) steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 60) begin
            infer_random();
         end else begin
            a = 7'($urandom());
            issue(CMD_WRITE, a, sane_coef(int'(a)));
         end
      end
      req_valid = 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (250) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #30000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* files.f */
rtl/mlpis_pkg.sv
rtl/mlpis_datapath.sv
rtl/mlpis_controller.sv
rtl/mlp_inference_with_input_scaling_core.sv
bench/mlp_inference_with_input_scaling_core_checker.sv
bench/mlp_inference_with_input_scaling_core_tb.sv
